[rtl/aph_pkg.sv]
package aph_pkg;

    localparam int SCORE_W   = 17;
    localparam int COUNT_W   = 4;
    localparam int TIMER_W   = 8;
    localparam int WARMUP_W  = 16;
    localparam int WINDOW_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 17;

    localparam logic [SCORE_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

    typedef enum logic [1:0] {
        PH_WARMUP = 2'd0,
        PH_NORMAL = 2'd1,
        PH_SUSP   = 2'd2,
        PH_ATTACK = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUSP_THR   = 3'd0,
        CFG_ATTACK_THR = 3'd1,
        CFG_RECOV_THR  = 3'd2,
        CFG_PERSIST    = 3'd3,
        CFG_ATK_RECOV  = 3'd4,
        CFG_FREEZE     = 3'd5,
        CFG_THAW       = 3'd6,
        CFG_WARMUP     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0]  suspicious_threshold;
        logic [SCORE_W-1:0]  attack_threshold;
        logic [SCORE_W-1:0]  recovery_threshold;
        logic [COUNT_W-1:0]  persistence_windows;
        logic [COUNT_W-1:0]  attack_recovery_windows;
        logic [TIMER_W-1:0]  freeze_windows;
        logic [TIMER_W-1:0]  thaw_windows;
        logic [WARMUP_W-1:0] warmup_windows;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        suspicious_threshold:    17'd32768,
        attack_threshold:        17'd45875,
        recovery_threshold:      17'd19661,
        persistence_windows:     4'd3,
        attack_recovery_windows: 4'd5,
        freeze_windows:          8'd60,
        thaw_windows:            8'd30,
        warmup_windows:          16'd60
    };

    typedef struct packed {
        t_phase              phase_now;
        t_phase              phase_before;
        logic                phase_changed;
        logic [SCORE_W-1:0]  attack_evidence;
        logic [COUNT_W-1:0]  persistence_count;
        logic                baseline_frozen;
        logic                thaw_active;
        logic [WINDOW_W-1:0] window_number;
        logic [WINDOW_W-1:0] last_change_window;
    } t_res;

    function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

[rtl/aph_win_if.sv]
interface aph_win_if;
    import aph_pkg::*;

    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] tier0_score;
    logic [SCORE_W-1:0] tier1_score;

    modport source (output valid, output tier0_score, output tier1_score, input ready);
    modport sink   (input valid, input tier0_score, input tier1_score, output ready);
endinterface

[rtl/aph_res_if.sv]
interface aph_res_if;
    import aph_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          phase_now;
    logic [1:0]          phase_before;
    logic                phase_changed;
    logic [SCORE_W-1:0]  attack_evidence;
    logic [COUNT_W-1:0]  persistence_count;
    logic                baseline_frozen;
    logic                thaw_active;
    logic [WINDOW_W-1:0] window_number;
    logic [WINDOW_W-1:0] last_change_window;

    modport source (
        output valid, output phase_now, output phase_before, output phase_changed,
        output attack_evidence, output persistence_count, output baseline_frozen,
        output thaw_active, output window_number, output last_change_window,
        input ready
    );
    modport sink (
        input valid, input phase_now, input phase_before, input phase_changed,
        input attack_evidence, input persistence_count, input baseline_frozen,
        input thaw_active, input window_number, input last_change_window,
        output ready
    );
endinterface

[rtl/attack_phase_hysteresis_fsm.sv]
// An accepted input word is registered in the input register, then its result word in the result register on o_res.
// Throughput: one word per cycle while o_res is ready; input and result registers each hold one word,
// and the phase state updates in the single cycle that moves a word into the result register.
// Reset (synchronous, active low): phase warmup, all counters and timers zero,
// configuration registers to their default values, both pipeline registers empty.
module attack_phase_hysteresis_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    aph_win_if.sink                         i_win,
    aph_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [aph_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aph_pkg::CFG_W-1:0]       i_cfg_data
);
    import aph_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_vld;
    logic [SCORE_W-1:0] r_ev;
    logic [SCORE_W-1:0] n_ev;
    logic               r_out_vld;
    t_res               r_res;
    t_res               core_res;
    logic               out_adv;
    logic               in_adv;
    logic [SCORE_W-1:0] s0;
    logic [SCORE_W-1:0] s1;

    assign out_adv     = !r_out_vld || o_res.ready;
    assign in_adv      = !r_in_vld || out_adv;
    assign i_win.ready = in_adv;

    assign s0   = clamp_score(i_win.tier0_score);
    assign s1   = clamp_score(i_win.tier1_score);
    assign n_ev = (s0 > s1) ? s0 : s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SUSP_THR:   r_cfg.suspicious_threshold    <= i_cfg_data[SCORE_W-1:0];
                CFG_ATTACK_THR: r_cfg.attack_threshold        <= i_cfg_data[SCORE_W-1:0];
                CFG_RECOV_THR:  r_cfg.recovery_threshold      <= i_cfg_data[SCORE_W-1:0];
                CFG_PERSIST:    r_cfg.persistence_windows     <= i_cfg_data[COUNT_W-1:0];
                CFG_ATK_RECOV:  r_cfg.attack_recovery_windows <= i_cfg_data[COUNT_W-1:0];
                CFG_FREEZE:     r_cfg.freeze_windows          <= i_cfg_data[TIMER_W-1:0];
                CFG_THAW:       r_cfg.thaw_windows            <= i_cfg_data[TIMER_W-1:0];
                CFG_WARMUP:     r_cfg.warmup_windows          <= i_cfg_data[WARMUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_vld <= i_win.valid;
            end
            if (out_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_win.valid) begin
            r_ev <= n_ev;
        end
        if (out_adv && r_in_vld) begin
            r_res <= core_res;
        end
    end

    aph_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (out_adv && r_in_vld),
        .i_ev    (r_ev),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    assign o_res.valid              = r_out_vld;
    assign o_res.phase_now          = r_res.phase_now;
    assign o_res.phase_before       = r_res.phase_before;
    assign o_res.phase_changed      = r_res.phase_changed;
    assign o_res.attack_evidence    = r_res.attack_evidence;
    assign o_res.persistence_count  = r_res.persistence_count;
    assign o_res.baseline_frozen    = r_res.baseline_frozen;
    assign o_res.thaw_active        = r_res.thaw_active;
    assign o_res.window_number      = r_res.window_number;
    assign o_res.last_change_window = r_res.last_change_window;

endmodule

[rtl/aph_core.sv]
module aph_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [aph_pkg::SCORE_W-1:0]   i_ev,
    input  aph_pkg::t_cfg                 i_cfg,
    output aph_pkg::t_res                 o_res
);
    import aph_pkg::*;

    t_phase              r_phase,  n_phase;
    t_phase              r_prior,  n_prior;
    logic [WARMUP_W-1:0] r_warm,   n_warm;
    logic [COUNT_W-1:0]  r_cnt,    n_cnt;
    logic [TIMER_W-1:0]  r_freeze, n_freeze;
    logic [TIMER_W-1:0]  r_thaw,   n_thaw;
    logic [WINDOW_W-1:0] r_win,    n_win;
    logic [WINDOW_W-1:0] r_chg,    n_chg;

    logic [COUNT_W-1:0]  cnt_inc;
    logic [COUNT_W-1:0]  cnt_dec;
    logic                in_warmup;
    logic                changed;

    always_comb begin
        cnt_inc   = (r_cnt != COUNT_MAX) ? r_cnt + COUNT_W'(1) : r_cnt;
        cnt_dec   = (r_cnt != '0) ? r_cnt - COUNT_W'(1) : r_cnt;
        in_warmup = (r_warm < i_cfg.warmup_windows);

        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_warm   = r_warm;
        n_freeze = (r_freeze != '0) ? r_freeze - TIMER_W'(1) : r_freeze;
        n_thaw   = (r_thaw != '0) ? r_thaw - TIMER_W'(1) : r_thaw;

        if (in_warmup) begin
            n_warm = r_warm + WARMUP_W'(1);
            if (n_warm == i_cfg.warmup_windows && r_phase == PH_WARMUP) begin
                n_phase = PH_NORMAL;
            end
        end else begin
            case (r_phase)
                PH_WARMUP: begin
                    n_phase = PH_NORMAL;
                end
                PH_NORMAL: begin
                    if (i_ev > i_cfg.suspicious_threshold) begin
                        n_phase = PH_SUSP;
                        n_cnt   = COUNT_W'(1);
                    end
                end
                PH_SUSP: begin
                    if (i_ev > i_cfg.attack_threshold) begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.persistence_windows) begin
                            n_phase  = PH_ATTACK;
                            n_freeze = i_cfg.freeze_windows;
                            n_cnt    = i_cfg.attack_recovery_windows;
                        end
                    end else if (i_ev < i_cfg.recovery_threshold) begin
                        n_cnt = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_phase = PH_NORMAL;
                        end
                    end
                end
                PH_ATTACK: begin
                    if (i_ev < i_cfg.recovery_threshold) begin
                        n_cnt = cnt_dec;
                        if (cnt_dec == '0) begin
                            n_phase = PH_NORMAL;
                            n_thaw  = i_cfg.thaw_windows;
                        end
                    end else begin
                        n_cnt = i_cfg.attack_recovery_windows;
                    end
                end
                default: begin
                    n_phase = PH_NORMAL;
                end
            endcase
        end

        changed = (n_phase != r_phase);
        n_prior = changed ? r_phase : r_prior;
        n_chg   = changed ? r_win : r_chg;
        n_win   = r_win + WINDOW_W'(1);

        o_res.phase_now          = n_phase;
        o_res.phase_before       = n_prior;
        o_res.phase_changed      = changed;
        o_res.attack_evidence    = i_ev;
        o_res.persistence_count  = n_cnt;
        o_res.baseline_frozen    = (n_freeze != '0);
        o_res.thaw_active        = (n_thaw != '0);
        o_res.window_number      = r_win;
        o_res.last_change_window = n_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WARMUP;
            r_prior  <= PH_WARMUP;
            r_warm   <= '0;
            r_cnt    <= '0;
            r_freeze <= '0;
            r_thaw   <= '0;
            r_win    <= '0;
            r_chg    <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_prior  <= n_prior;
            r_warm   <= n_warm;
            r_cnt    <= n_cnt;
            r_freeze <= n_freeze;
            r_thaw   <= n_thaw;
            r_win    <= n_win;
            r_chg    <= n_chg;
        end
    end

    a_no_normal_to_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && r_phase == PH_NORMAL && n_phase == PH_ATTACK))
        else $error("normal phase jumped straight to attack");

    a_freeze_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && changed && n_phase == PH_ATTACK) |=>
            r_freeze == $past(i_cfg.freeze_windows))
        else $error("freeze timer not loaded on entering attack");

    a_win_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_win == WINDOW_W'($past(r_win) + WINDOW_W'(1)))
        else $error("window counter did not advance");

    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_win) && $stable(r_phase) && $stable(r_cnt))
        else $error("state moved without a window");

    a_change_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && changed) |=> r_chg == $past(r_win) && r_prior == $past(r_phase))
        else $error("phase change not recorded");

endmodule

[tb/aph_phase_chk.sv]
`timescale 1ns / 100ps

module aph_phase_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aph_win_if                            i_win,
    aph_res_if                            i_res,
    input  logic                          i_cfg_we,
    input  logic [aph_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [aph_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import aph_pkg::*;

    t_cfg                settings;
    t_phase              phase_q;
    t_phase              prior_q;
    logic [WARMUP_W-1:0] warm_cnt;
    logic [COUNT_W-1:0]  run_cnt;
    logic [TIMER_W-1:0]  freeze_cnt;
    logic [TIMER_W-1:0]  thaw_cnt;
    logic [WINDOW_W-1:0] win_cnt;
    logic [WINDOW_W-1:0] change_win;

    t_res report_q [$];
    t_res want;
    t_res got;
    int   mismatch_n = 0;

    assign o_fail_count = mismatch_n;

    function automatic string report_text(input t_res r);
        return $sformatf(
            "phase %0d prior %0d chg %0b ev %0d cnt %0d frz %0b thaw %0b win %0d last %0d",
            r.phase_now, r.phase_before, r.phase_changed, r.attack_evidence,
            r.persistence_count, r.baseline_frozen, r.thaw_active,
            r.window_number, r.last_change_window);
    endfunction

    task automatic take_setting(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_SUSP_THR:   settings.suspicious_threshold    = val[SCORE_W-1:0];
            CFG_ATTACK_THR: settings.attack_threshold        = val[SCORE_W-1:0];
            CFG_RECOV_THR:  settings.recovery_threshold      = val[SCORE_W-1:0];
            CFG_PERSIST:    settings.persistence_windows     = val[COUNT_W-1:0];
            CFG_ATK_RECOV:  settings.attack_recovery_windows = val[COUNT_W-1:0];
            CFG_FREEZE:     settings.freeze_windows          = val[TIMER_W-1:0];
            CFG_THAW:       settings.thaw_windows            = val[TIMER_W-1:0];
            CFG_WARMUP:     settings.warmup_windows          = val[WARMUP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_phase(input logic [SCORE_W-1:0] t0, input logic [SCORE_W-1:0] t1,
                                 output t_res r);
        logic [SCORE_W-1:0]  a;
        logic [SCORE_W-1:0]  b;
        logic [SCORE_W-1:0]  ev;
        t_phase              old;
        logic [WINDOW_W-1:0] win;

        a   = (t0 > ONE_Q16) ? ONE_Q16 : t0;
        b   = (t1 > ONE_Q16) ? ONE_Q16 : t1;
        ev  = (a > b) ? a : b;
        old = phase_q;
        win = win_cnt;

        if (freeze_cnt != '0) freeze_cnt = freeze_cnt - 1'b1;
        if (thaw_cnt != '0) thaw_cnt = thaw_cnt - 1'b1;

        if (warm_cnt < settings.warmup_windows) begin
            warm_cnt = warm_cnt + 1'b1;
            if (warm_cnt == settings.warmup_windows && phase_q == PH_WARMUP) phase_q = PH_NORMAL;
        end else begin
            case (phase_q)
                PH_WARMUP: phase_q = PH_NORMAL;
                PH_NORMAL: begin
                    if (ev > settings.suspicious_threshold) begin
                        phase_q = PH_SUSP;
                        run_cnt = COUNT_W'(1);
                    end
                end
                PH_SUSP: begin
                    if (ev > settings.attack_threshold) begin
                        if (run_cnt != COUNT_MAX) run_cnt = run_cnt + 1'b1;
                        if (run_cnt >= settings.persistence_windows) begin
                            phase_q    = PH_ATTACK;
                            freeze_cnt = settings.freeze_windows;
                            run_cnt    = settings.attack_recovery_windows;
                        end
                    end else if (ev < settings.recovery_threshold) begin
                        if (run_cnt != '0) run_cnt = run_cnt - 1'b1;
                        if (run_cnt == '0) phase_q = PH_NORMAL;
                    end
                end
                default: begin
                    if (ev < settings.recovery_threshold) begin
                        if (run_cnt != '0) run_cnt = run_cnt - 1'b1;
                        if (run_cnt == '0) begin
                            phase_q  = PH_NORMAL;
                            thaw_cnt = settings.thaw_windows;
                        end
                    end else begin
                        run_cnt = settings.attack_recovery_windows;
                    end
                end
            endcase
        end

        r.phase_changed = (phase_q != old);
        if (r.phase_changed) begin
            prior_q    = old;
            change_win = win;
        end
        win_cnt = win + 1'b1;

        r.phase_now          = phase_q;
        r.phase_before       = prior_q;
        r.attack_evidence    = ev;
        r.persistence_count  = run_cnt;
        r.baseline_frozen    = (freeze_cnt != '0);
        r.thaw_active        = (thaw_cnt != '0);
        r.window_number      = win;
        r.last_change_window = change_win;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings   = CFG_RESET;
            phase_q    = PH_WARMUP;
            prior_q    = PH_WARMUP;
            warm_cnt   = '0;
            run_cnt    = '0;
            freeze_cnt = '0;
            thaw_cnt   = '0;
            win_cnt    = '0;
            change_win = '0;
            report_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) take_setting(t_cfg_idx'(i_cfg_idx), i_cfg_data);

            if (i_res.valid && i_res.ready) begin
                got.phase_now          = t_phase'(i_res.phase_now);
                got.phase_before       = t_phase'(i_res.phase_before);
                got.phase_changed      = i_res.phase_changed;
                got.attack_evidence    = i_res.attack_evidence;
                got.persistence_count  = i_res.persistence_count;
                got.baseline_frozen    = i_res.baseline_frozen;
                got.thaw_active        = i_res.thaw_active;
                got.window_number      = i_res.window_number;
                got.last_change_window = i_res.last_change_window;
                if (report_q.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10) $display("unexpected word: %s", report_text(got));
                end else begin
                    want = report_q.pop_front();
                    if (got !== want) begin
                        mismatch_n++;
                        if (mismatch_n <= 10) begin
                            $display("mismatch on window %0d", want.window_number);
                            $display("  expected %s", report_text(want));
                            $display("  actual   %s", report_text(got));
                        end
                    end
                end
            end

            if (i_win.valid && i_win.ready) begin
                advance_phase(i_win.tier0_score, i_win.tier1_score, want);
                report_q.push_back(want);
            end

            o_pending <= report_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import aph_pkg::*;

    typedef enum int {
        EV_HIGH,
        EV_CALM,
        EV_MID,
        EV_EDGE,
        EV_WILD
    } t_ev_kind;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_n;
    int                   pending_n;

    bit                   tx_calm = 1'b0;
    bit                   rx_calm = 1'b0;
    int unsigned          cur_susp;
    int unsigned          cur_atk;
    int unsigned          cur_rec;

    aph_win_if win ();
    aph_res_if res ();

    attack_phase_hysteresis_fsm dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_win      (win),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    aph_phase_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_win        (win),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_n),
        .o_pending    (pending_n)
    );

    always #10 clk = ~clk;

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls with calm stretches
    initial begin
        int stall;
        res.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
        end
    end

    task automatic send_word(input logic [SCORE_W-1:0] t0, input logic [SCORE_W-1:0] t1);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            win.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        win.valid       <= 1'b1;
        win.tier0_score <= t0;
        win.tier1_score <= t1;
        do @(posedge clk); while (!win.ready);
    endtask

    task automatic settle();
        win.valid <= 1'b0;
        do @(posedge clk); while (pending_n != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(CFG_SUSP_THR,   c.suspicious_threshold);
        write_reg(CFG_ATTACK_THR, c.attack_threshold);
        write_reg(CFG_RECOV_THR,  c.recovery_threshold);
        write_reg(CFG_PERSIST,    CFG_W'(c.persistence_windows));
        write_reg(CFG_ATK_RECOV,  CFG_W'(c.attack_recovery_windows));
        write_reg(CFG_FREEZE,     CFG_W'(c.freeze_windows));
        write_reg(CFG_THAW,       CFG_W'(c.thaw_windows));
        write_reg(CFG_WARMUP,     CFG_W'(c.warmup_windows));
        cfg_we   <= 1'b0;
        cur_susp = 32'(c.suspicious_threshold);
        cur_atk  = 32'(c.attack_threshold);
        cur_rec  = 32'(c.recovery_threshold);
    endtask

    function automatic t_cfg phase_settings(input int ph);
        t_cfg        c;
        int unsigned x;
        int unsigned y;
        int unsigned z;
        int unsigned tmp;

        c = CFG_RESET;
        case (ph)
            0: c.warmup_windows = '0;
            1: c = '0;
            2: begin
                c.persistence_windows     = '0;
                c.attack_recovery_windows = '0;
                c.freeze_windows          = 8'd1;
                c.thaw_windows            = 8'd1;
                c.warmup_windows          = '0;
            end
            3: begin
                c.suspicious_threshold    = 17'h1FFFF;
                c.attack_threshold        = 17'h1FFFF;
                c.recovery_threshold      = 17'h1FFFF;
                c.persistence_windows     = COUNT_MAX;
                c.attack_recovery_windows = COUNT_MAX;
                c.freeze_windows          = 8'hFF;
                c.thaw_windows            = 8'hFF;
                c.warmup_windows          = 16'hFFFF;
            end
            4: begin
                c.persistence_windows     = COUNT_MAX;
                c.attack_recovery_windows = COUNT_MAX;
                c.freeze_windows          = 8'hFF;
                c.thaw_windows            = 8'hFF;
                c.warmup_windows          = 16'd10;
            end
            default: begin
                x = $urandom_range(0, ONE_Q16);
                y = $urandom_range(0, ONE_Q16);
                z = $urandom_range(0, ONE_Q16);
                if (x > y) begin tmp = x; x = y; y = tmp; end
                if (y > z) begin tmp = y; y = z; z = tmp; end
                if (x > y) begin tmp = x; x = y; y = tmp; end
                if ($urandom_range(0, 5) == 0) begin
                    x = $urandom_range(0, 17'h1FFFF);
                    y = $urandom_range(0, 17'h1FFFF);
                    z = $urandom_range(0, 17'h1FFFF);
                end
                c.recovery_threshold      = SCORE_W'(x);
                c.suspicious_threshold    = SCORE_W'(y);
                c.attack_threshold        = SCORE_W'(z);
                c.persistence_windows     = COUNT_W'($urandom_range(0, 15));
                c.attack_recovery_windows = COUNT_W'($urandom_range(0, 15));
                c.freeze_windows          = TIMER_W'($urandom_range(0, 255));
                c.thaw_windows            = TIMER_W'($urandom_range(0, 255));
                c.warmup_windows          = ($urandom_range(0, 3) == 0) ?
                                            WARMUP_W'($urandom_range(0, 2000)) : '0;
            end
        endcase
        return c;
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score(input t_ev_kind kind);
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        tmp;
        logic [SCORE_W-1:0] v;

        case (kind)
            EV_HIGH: begin
                lo = ((cur_atk > cur_susp) ? cur_atk : cur_susp) + 1;
                if ($urandom_range(0, 7) == 0 || lo > ONE_Q16) begin
                    v = SCORE_W'($urandom_range(ONE_Q16, 17'h1FFFF));
                end else begin
                    v = SCORE_W'($urandom_range(lo, ONE_Q16));
                end
            end
            EV_CALM: begin
                if (cur_rec == 0) v = '0;
                else v = SCORE_W'($urandom_range(0, (cur_rec > ONE_Q16) ? ONE_Q16 : cur_rec - 1));
            end
            EV_MID: begin
                lo = (cur_rec > ONE_Q16) ? ONE_Q16 : cur_rec;
                hi = (cur_atk > ONE_Q16) ? ONE_Q16 : cur_atk;
                if (lo > hi) begin tmp = lo; lo = hi; hi = tmp; end
                v = SCORE_W'($urandom_range(lo, hi));
            end
            EV_EDGE: begin
                case ($urandom_range(0, 5))
                    0:       v = SCORE_W'(cur_susp);
                    1:       v = SCORE_W'(cur_susp + 1);
                    2:       v = SCORE_W'(cur_atk);
                    3:       v = SCORE_W'(cur_atk + 1);
                    4:       v = SCORE_W'(cur_rec);
                    default: v = SCORE_W'(cur_rec - 1);
                endcase
            end
            default: v = SCORE_W'($urandom_range(0, 17'h1FFFF));
        endcase
        return v;
    endfunction

    task automatic send_pair(input t_ev_kind kind);
        logic [SCORE_W-1:0] lead;
        logic [SCORE_W-1:0] other;
        lead = pick_score(kind);
        if ($urandom_range(0, 1) == 0) other = pick_score(kind);
        else other = SCORE_W'($urandom_range(0, (lead > ONE_Q16) ? ONE_Q16 : lead));
        if ($urandom_range(0, 1) == 0) send_word(lead, other);
        else send_word(other, lead);
    endtask

    initial begin
        int       ph;
        int       n_left;
        int       run;
        int       pct;
        t_ev_kind kind;

        win.valid       <= 1'b0;
        win.tier0_score <= '0;
        win.tier1_score <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_SUSP_THR;
        cfg_data        <= '0;
        cur_susp = 32'(CFG_RESET.suspicious_threshold);
        cur_atk  = 32'(CFG_RESET.attack_threshold);
        cur_rec  = 32'(CFG_RESET.recovery_threshold);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // warmup under reset settings, then cut warmup short
        send_word(17'd0, 17'h10000);
        send_word(17'h1FFFF, 17'd0);
        settle();
        write_reg(CFG_WARMUP, ($urandom_range(0, 1) == 0) ? 17'd0 : 17'd3);
        cfg_we <= 1'b0;

        send_word(17'h15555, 17'h0AAAA);
        send_word(17'h10000, 17'd0);
        send_word(17'h1FFFF, 17'h1FFFF);
        send_word(17'h10001, 17'd5);
        send_word(17'd45875, 17'd45875);
        send_word(17'd19661, 17'd0);
        send_word(17'd19660, 17'd0);
        send_word(17'd0, 17'd19660);
        send_word(17'd0, 17'd0);
        send_word(17'd100, 17'd19000);
        send_word(17'd0, 17'd1);
        send_word(17'd32768, 17'd32768);
        send_word(17'd0, 17'd32769);
        send_word(17'd45875, 17'd0);
        send_word(17'd0, 17'd0);
        send_word(17'h0AAAA, 17'h15555);
        send_word(17'd19660, 17'd0);

        for (ph = 0; ph < 12; ph++) begin
            settle();
            load_settings(phase_settings(ph));
            case (ph)
                0:       n_left = 200;
                1:       n_left = 60;
                2:       n_left = 150;
                3:       n_left = 40;
                4:       n_left = 250;
                default: n_left = 115;
            endcase
            while (n_left > 0) begin
                pct = $urandom_range(0, 99);
                if (pct < 35) kind = EV_HIGH;
                else if (pct < 70) kind = EV_CALM;
                else if (pct < 82) kind = EV_MID;
                else if (pct < 90) kind = EV_EDGE;
                else kind = EV_WILD;
                run = $urandom_range(1, 20);
                if (run > n_left) run = n_left;
                n_left -= run;
                repeat (run) send_pair(kind);
            end
        end

        settle();
        if (fail_n == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[attack_phase_hysteresis_fsm.f]
rtl/aph_pkg.sv
rtl/aph_win_if.sv
rtl/aph_res_if.sv
rtl/aph_core.sv
rtl/attack_phase_hysteresis_fsm.sv
tb/aph_phase_chk.sv
tb/tb.sv
